FILE: rtl/core/bbe_pkg.sv
// Package with shared constants, command codes and types of the bitset bank engine.
package bbe_pkg;

   localparam int NUM_SETS_DEFAULT  = 8;
   localparam int SET_BYTES_DEFAULT = 32;

   localparam logic [5:0] BYTES_IN_USE_RESET = 6'd32;
   localparam logic [7:0] BYTE_MASK          = 8'hff;
   localparam logic [2:0] BIT_MASK           = 3'd7;

   typedef enum logic [3:0] {
      CMD_CLEAR  = 4'd0,
      CMD_INSERT = 4'd1,
      CMD_REMOVE = 4'd2,
      CMD_TEST   = 4'd3,
      CMD_UNION  = 4'd4,
      CMD_DIFF   = 4'd5,
      CMD_EMPTY  = 4'd6,
      CMD_EQUAL  = 4'd7,
      CMD_SUBSET = 4'd8,
      CMD_COUNT  = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SWEEP = 2'd1,
      ST_TAIL  = 2'd2,
      ST_DONE  = 2'd3
   } state_type;

   typedef struct packed {
      logic [3:0] command;
      logic [2:0] target_set;
      logic [2:0] first_set;
      logic [2:0] second_set;
      logic [7:0] element;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [8:0] member_count;
      logic       answer_flag;
   } rsp_type;

endpackage

FILE: rtl/core/bbe_store.sv
// Byte-wide set storage with two registered read ports and one write port.
module bbe_store #(
   parameter int DEPTH  = bbe_pkg::NUM_SETS_DEFAULT * bbe_pkg::SET_BYTES_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] rd_a_addr,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [7:0]        rd_a_data,
   output logic [7:0]        rd_b_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

FILE: rtl/core/bbe_seq.sv
// Command sequencer that sweeps set bytes through the store and forms each result.
module bbe_seq #(
   parameter int NUM_SETS  = bbe_pkg::NUM_SETS_DEFAULT,
   parameter int SET_BYTES = bbe_pkg::SET_BYTES_DEFAULT,
   parameter int ADDR_W    = $clog2(NUM_SETS * SET_BYTES),
   parameter int CNT_W     = $clog2(SET_BYTES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_W-1:0]  active_bytes,
   input  logic              req_valid,
   output logic              req_ready,
   input  bbe_pkg::req_type  req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bbe_pkg::rsp_type  rsp,
   output logic [ADDR_W-1:0] rd_a_addr,
   output logic [ADDR_W-1:0] rd_b_addr,
   input  logic [7:0]        rd_a_data,
   input  logic [7:0]        rd_b_data,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data
);

   localparam int SEL_W   = $clog2(NUM_SETS);
   localparam int BYTE_W  = (SET_BYTES > 1) ? $clog2(SET_BYTES) : 1;
   localparam int RANGE_W = (CNT_W + 3 > 9) ? CNT_W + 3 : 9;

   function automatic logic [SEL_W-1:0] set_index(input logic [2:0] sel);
      logic [6:0] v;
      v = {4'd0, sel};
      for (int i = 0; i < 4; i++) begin
         if (v >= 7'(NUM_SETS)) begin
            v = v - 7'(NUM_SETS);
         end
      end
      return SEL_W'(v);
   endfunction

   function automatic logic [ADDR_W-1:0] set_base(input logic [2:0] sel);
      return ADDR_W'(set_index(sel)) * ADDR_W'(SET_BYTES);
   endfunction

   bbe_pkg::state_type state_ff, state_in;
   bbe_pkg::cmd_type   cmd_ff, cmd_in;
   logic [ADDR_W-1:0]  base_a_ff, base_a_in;
   logic [ADDR_W-1:0]  base_b_ff, base_b_in;
   logic [ADDR_W-1:0]  base_t_ff, base_t_in;
   logic [BYTE_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [7:0]         bit_ff, bit_in;
   logic               p1_valid_ff, p1_valid_in;
   logic [BYTE_W-1:0]  p1_idx_ff, p1_idx_in;
   logic               flag_ff, flag_in;
   logic [8:0]         count_ff, count_in;
   logic               status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bbe_pkg::rsp_type   rsp_ff, rsp_in;

   bbe_pkg::cmd_type   req_cmd;
   logic               single;
   logic               known;
   logic               out_of_range;
   logic [RANGE_W-1:0] elem_limit;

   assign req_cmd    = bbe_pkg::cmd_type'(req.command);
   assign elem_limit = RANGE_W'({active_bytes, 3'b000});
   assign out_of_range = RANGE_W'(req.element) >= elem_limit;

   always_comb begin
      single = 1'b0;
      known  = 1'b1;
      case (req_cmd)
         bbe_pkg::CMD_INSERT, bbe_pkg::CMD_REMOVE, bbe_pkg::CMD_TEST: single = 1'b1;
         bbe_pkg::CMD_CLEAR, bbe_pkg::CMD_UNION, bbe_pkg::CMD_DIFF,
         bbe_pkg::CMD_EMPTY, bbe_pkg::CMD_EQUAL, bbe_pkg::CMD_SUBSET,
         bbe_pkg::CMD_COUNT: single = 1'b0;
         default: known = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbe_pkg::ST_IDLE;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      base_a_ff <= base_a_in;
      base_b_ff <= base_b_in;
      base_t_ff <= base_t_in;
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      bit_ff    <= bit_in;
      p1_idx_ff <= p1_idx_in;
      flag_ff   <= flag_in;
      count_ff  <= count_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      base_a_in    = base_a_ff;
      base_b_in    = base_b_ff;
      base_t_in    = base_t_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      bit_in       = bit_ff;
      p1_valid_in  = 1'b0;
      p1_idx_in    = idx_ff;
      flag_in      = flag_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;

      wr_en   = 1'b0;
      wr_addr = base_t_ff + ADDR_W'(p1_idx_ff);
      wr_data = 8'd0;

      if (p1_valid_ff) begin
         case (cmd_ff)
            bbe_pkg::CMD_CLEAR: begin
               wr_en   = 1'b1;
               wr_data = 8'd0;
            end
            bbe_pkg::CMD_INSERT: begin
               wr_en   = 1'b1;
               wr_data = rd_a_data | bit_ff;
            end
            bbe_pkg::CMD_REMOVE: begin
               wr_en   = 1'b1;
               wr_data = rd_a_data & (bbe_pkg::BYTE_MASK ^ bit_ff);
            end
            bbe_pkg::CMD_TEST:   flag_in = |(rd_a_data & bit_ff);
            bbe_pkg::CMD_UNION: begin
               wr_en   = 1'b1;
               wr_data = rd_a_data | rd_b_data;
            end
            bbe_pkg::CMD_DIFF: begin
               wr_en   = 1'b1;
               wr_data = rd_a_data & (bbe_pkg::BYTE_MASK ^ rd_b_data);
            end
            bbe_pkg::CMD_EMPTY:  flag_in = flag_ff & (rd_a_data == 8'd0);
            bbe_pkg::CMD_EQUAL:  flag_in = flag_ff & (rd_a_data == rd_b_data);
            bbe_pkg::CMD_SUBSET: flag_in = flag_ff & ((rd_a_data | rd_b_data) == rd_b_data);
            bbe_pkg::CMD_COUNT:  count_in = count_ff + 9'($countones(rd_a_data));
            default: ;
         endcase
      end

      case (state_ff)
         bbe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in    = req_cmd;
               base_a_in = (req_cmd == bbe_pkg::CMD_UNION || req_cmd == bbe_pkg::CMD_DIFF ||
                            req_cmd == bbe_pkg::CMD_EQUAL || req_cmd == bbe_pkg::CMD_SUBSET)
                           ? set_base(req.first_set) : set_base(req.target_set);
               base_b_in = set_base(req.second_set);
               base_t_in = set_base(req.target_set);
               idx_in    = single ? BYTE_W'(req.element >> 3) : BYTE_W'(0);
               left_in   = single ? CNT_W'(1) : active_bytes;
               bit_in    = 8'd1 << (req.element[2:0] & bbe_pkg::BIT_MASK);
               flag_in   = (req_cmd == bbe_pkg::CMD_EMPTY || req_cmd == bbe_pkg::CMD_EQUAL ||
                            req_cmd == bbe_pkg::CMD_SUBSET);
               count_in  = 9'd0;
               status_in = single & out_of_range;
               if (!known || (single && out_of_range)) begin
                  state_in = bbe_pkg::ST_DONE;
               end else begin
                  state_in = bbe_pkg::ST_SWEEP;
               end
            end
         end
         bbe_pkg::ST_SWEEP: begin
            p1_valid_in = 1'b1;
            idx_in      = idx_ff + BYTE_W'(1);
            left_in     = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               state_in = bbe_pkg::ST_TAIL;
            end
         end
         bbe_pkg::ST_TAIL: begin
            state_in = bbe_pkg::ST_DONE;
         end
         bbe_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.answer_flag  = flag_ff;
               rsp_in.member_count = count_ff;
               rsp_in.status       = status_ff;
               state_in            = bbe_pkg::ST_IDLE;
            end
         end
         default: state_in = bbe_pkg::ST_IDLE;
      endcase
   end

   assign rd_a_addr = base_a_ff + ADDR_W'(idx_ff);
   assign rd_b_addr = base_b_ff + ADDR_W'(idx_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/core/bitset_bank_engine.sv
// Top level of the bitset bank engine with the size register and stream ports.
// Each request transfer carries one command on a bank of NUM_SETS bitsets of SET_BYTES bytes,
// of which the first bytes_in_use bytes (at least one, at most SET_BYTES) are in use; every
// command returns exactly one response transfer. Commands run one at a time through a
// byte-wide store with two read ports and one write port, one byte per cycle: clear, union,
// diff, empty, equal, subset and count sweep all bytes in use, insert, remove and test only
// the byte that holds the element, and an out-of-range element or an unknown command sweeps
// no byte. The next request is taken only after the response is loaded. A new request is
// taken while an earlier response still waits in the output register; the new response then
// waits until that one is taken. Sets are not cleared at reset; a set must be cleared before
// it is read.
module bitset_bank_engine #(
   parameter int NUM_SETS  = bbe_pkg::NUM_SETS_DEFAULT,
   parameter int SET_BYTES = bbe_pkg::SET_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[3:0], target_set[6:4], first_set[9:7], second_set[12:10], element[20:13], zeros
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // answer_flag[0], member_count[9:1], status[10], zeros
   output logic [15:0] rsp_tdata
);

   localparam int DEPTH  = NUM_SETS * SET_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(SET_BYTES + 1);

   logic [5:0]        bytes_in_use_ff;
   logic [CNT_W-1:0]  active_bytes;
   bbe_pkg::req_type  req;
   bbe_pkg::rsp_type  rsp;
   logic [ADDR_W-1:0] rd_a_addr;
   logic [ADDR_W-1:0] rd_b_addr;
   logic [7:0]        rd_a_data;
   logic [7:0]        rd_b_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_in_use_ff <= bbe_pkg::BYTES_IN_USE_RESET;
      end else if (csr_wr_en) begin
         bytes_in_use_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (bytes_in_use_ff == 6'd0) begin
         active_bytes = CNT_W'(1);
      end else if (10'(bytes_in_use_ff) > 10'(SET_BYTES)) begin
         active_bytes = CNT_W'(SET_BYTES);
      end else begin
         active_bytes = CNT_W'(bytes_in_use_ff);
      end
   end

   assign req.command    = req_tdata[3:0];
   assign req.target_set = req_tdata[6:4];
   assign req.first_set  = req_tdata[9:7];
   assign req.second_set = req_tdata[12:10];
   assign req.element    = req_tdata[20:13];

   assign rsp_tdata = {5'd0, rsp.status, rsp.member_count, rsp.answer_flag};

   bbe_seq #(
      .NUM_SETS  (NUM_SETS),
      .SET_BYTES (SET_BYTES),
      .ADDR_W    (ADDR_W),
      .CNT_W     (CNT_W)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .active_bytes (active_bytes),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req          (req),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp          (rsp),
      .rd_a_addr    (rd_a_addr),
      .rd_b_addr    (rd_b_addr),
      .rd_a_data    (rd_a_data),
      .rd_b_data    (rd_b_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   bbe_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

endmodule

FILE: rtl/core/bbe_checker.sv
// Port-level checker of the bitset bank engine and its bind to the top level.
module bbe_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        csr_wr_en,
   input logic [5:0]  csr_wr_data,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Response valid right after reset.");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled response changed.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Request taken while a command is in progress.");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[9:0] == 10'd0)
      else $error("Out-of-range response carries an answer or a count.");

   a_count_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9:1] != 9'd0 |-> !rsp_tdata[0] && !rsp_tdata[10])
      else $error("Count response carries a flag or a status.");

endmodule

bind bitset_bank_engine bbe_port_checks u_bbe_port_checks (
   .clock       (clock),
   .reset       (reset),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .req_tdata   (req_tdata),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata)
);

FILE: dv/bbe_checker.sv
// Checker that predicts every bitset bank engine response and compares each response transfer.
module bbe_checker #(
   parameter int NUM_SETS  = bbe_pkg::NUM_SETS_DEFAULT,
   parameter int SET_BYTES = bbe_pkg::SET_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   output int          fail_count,
   output int          answers_due
);
   import bbe_pkg::*;

   logic [7:0] bank [NUM_SETS][SET_BYTES];
   logic [5:0] size_reg;
   rsp_type    expected_answers [$];
   rsp_type    want;

   initial begin
      fail_count = 0;
      answers_due = 0;
      size_reg = BYTES_IN_USE_RESET;
      for (int s = 0; s < NUM_SETS; s++) begin
         for (int w = 0; w < SET_BYTES; w++) begin
            bank[s][w] = 8'h00;
         end
      end
   end

   function automatic rsp_type apply_command(input logic [23:0] word);
      logic [3:0] op;
      logic [7:0] elem;
      logic [7:0] mask;
      int         t;
      int         a;
      int         b;
      int         n;
      rsp_type    r;
      op = word[3:0];
      t = word[6:4] % NUM_SETS;
      a = word[9:7] % NUM_SETS;
      b = word[12:10] % NUM_SETS;
      elem = word[20:13];
      mask = 8'd1 << elem[2:0];
      n = (size_reg == 6'd0) ? 1 : ((size_reg > SET_BYTES) ? SET_BYTES : int'(size_reg));
      r = '0;
      case (op)
         CMD_CLEAR: begin
            for (int w = 0; w < n; w++) bank[t][w] = 8'h00;
         end
         CMD_INSERT, CMD_REMOVE, CMD_TEST: begin
            if (int'(elem) >= 8 * n) begin
               r.status = 1'b1;
            end else if (op == CMD_INSERT) begin
               bank[t][elem[7:3]] = bank[t][elem[7:3]] | mask;
            end else if (op == CMD_REMOVE) begin
               bank[t][elem[7:3]] = bank[t][elem[7:3]] & (BYTE_MASK ^ mask);
            end else begin
               r.answer_flag = |(bank[t][elem[7:3]] & mask);
            end
         end
         CMD_UNION: begin
            for (int w = 0; w < n; w++) bank[t][w] = bank[a][w] | bank[b][w];
         end
         CMD_DIFF: begin
            for (int w = 0; w < n; w++) bank[t][w] = bank[a][w] & (BYTE_MASK ^ bank[b][w]);
         end
         CMD_EMPTY: begin
            r.answer_flag = 1'b1;
            for (int w = 0; w < n; w++) begin
               if (bank[t][w] != 8'h00) r.answer_flag = 1'b0;
            end
         end
         CMD_EQUAL: begin
            r.answer_flag = 1'b1;
            for (int w = 0; w < n; w++) begin
               if (bank[a][w] != bank[b][w]) r.answer_flag = 1'b0;
            end
         end
         CMD_SUBSET: begin
            r.answer_flag = 1'b1;
            for (int w = 0; w < n; w++) begin
               if ((bank[a][w] | bank[b][w]) != bank[b][w]) r.answer_flag = 1'b0;
            end
         end
         CMD_COUNT: begin
            for (int w = 0; w < n; w++) begin
               r.member_count = r.member_count + 9'($countones(bank[t][w]));
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [8:0] exp_val,
                                       input logic [8:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s expected %0d actual %0d", name, exp_val, got_val);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         size_reg = BYTES_IN_USE_RESET;
         expected_answers.delete();
      end else begin
         if (csr_wr_en) size_reg = csr_wr_data;
         if (req_tvalid && req_tready) expected_answers.push_back(apply_command(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               $error("response transfer with no command outstanding, tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_answers.pop_front();
               check_field("answer_flag", 9'(want.answer_flag), 9'(rsp_tdata[0]));
               check_field("member_count", want.member_count, rsp_tdata[9:1]);
               check_field("status", 9'(want.status), 9'(rsp_tdata[10]));
            end
         end
      end
      answers_due = expected_answers.size();
   end

endmodule

FILE: dv/tb_top.sv
// Testbench top that drives commands, size settings and response stalls into the bitset bank engine.
module tb_top;
   import bbe_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD   = 300;
   localparam int PHASE_ITEMS = 170;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [5:0]  csr_wr_data = 6'd0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = 24'd0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;

   int fail_count;
   int answers_due;
   int cycle_count = 0;
   bit steady      = 1'b0;
   bit hold_req    = 1'b0;

   always #5 clock = ~clock;

   bitset_bank_engine uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   bbe_checker bank_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .answers_due (answers_due)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic issue(input logic [3:0] op, input int t, input int a, input int b,
                        input int e);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {3'b000, e[7:0], b[2:0], a[2:0], t[2:0], op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
   endtask

   task automatic random_item(input int span);
      int         pick;
      int         a;
      int         e;
      logic [3:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 4) op = CMD_CLEAR;
      else if (pick < 34) op = CMD_INSERT;
      else if (pick < 44) op = CMD_REMOVE;
      else if (pick < 54) op = CMD_TEST;
      else if (pick < 61) op = CMD_UNION;
      else if (pick < 67) op = CMD_DIFF;
      else if (pick < 73) op = CMD_EMPTY;
      else if (pick < 80) op = CMD_EQUAL;
      else if (pick < 86) op = CMD_SUBSET;
      else if (pick < 94) op = CMD_COUNT;
      else op = 4'($urandom_range(10, 15));
      a = $urandom_range(0, 7);
      e = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8 * span - 1);
      issue(op, $urandom_range(0, 7), a, ($urandom_range(0, 3) == 0) ? a : $urandom_range(0, 7),
            e);
   endtask

   task automatic drain(input int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_due != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_size(input logic [5:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : response_sink
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = steady ? 0 : $urandom_range(0, 5);
         if (hold_req) begin
            hold = LONG_HOLD;
            hold_req = 1'b0;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [5:0] sizes [8] = '{6'd63, 6'd0, 6'd1, 6'd33, 6'd32, 6'd5, 6'd17, 6'd0};
      int         span;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Every set is cleared over its full width first, so no byte is ever read unwritten.
      for (int s = 0; s < 8; s++) issue(CMD_CLEAR, s, 0, 0, 0);
      issue(CMD_INSERT, 0, 0, 0, 0);
      issue(CMD_INSERT, 0, 0, 0, 255);
      issue(CMD_INSERT, 1, 0, 0, 255);
      issue(CMD_TEST, 0, 0, 0, 255);
      issue(CMD_TEST, 0, 0, 0, 128);
      issue(CMD_REMOVE, 0, 0, 0, 0);
      issue(CMD_UNION, 2, 0, 1, 0);
      issue(CMD_UNION, 2, 2, 0, 0);
      issue(CMD_DIFF, 3, 2, 1, 0);
      issue(CMD_DIFF, 1, 0, 1, 0);
      issue(CMD_EMPTY, 3, 0, 0, 0);
      issue(CMD_EMPTY, 2, 0, 0, 0);
      issue(CMD_EQUAL, 0, 0, 2, 0);
      issue(CMD_SUBSET, 0, 3, 2, 0);
      issue(CMD_SUBSET, 0, 2, 3, 0);
      issue(CMD_COUNT, 2, 0, 0, 0);
      issue(4'd15, 7, 7, 7, 255);
      drain(4);

      for (int p = 0; p < 8; p++) begin
         if (p == 7) sizes[p] = 6'($urandom_range(2, 62));
         write_size(sizes[p]);
         span = (sizes[p] == 6'd0) ? 1 : ((sizes[p] > 6'd32) ? 32 : int'(sizes[p]));
         if (sizes[p] == 6'd1) begin
            issue(CMD_INSERT, 7, 0, 0, 8);
            issue(CMD_TEST, 7, 0, 0, 255);
            issue(CMD_INSERT, 7, 0, 0, 7);
            issue(CMD_TEST, 7, 0, 0, 7);
            issue(CMD_REMOVE, 7, 0, 0, 200);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 50 == 0) steady = ($urandom_range(0, 2) == 0);
            if (p == 0 && i == 40) hold_req = 1'b1;
            random_item(span);
         end
         drain((p == 7) ? 40 : 4);
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
